FILE: sv/atmv_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// atmv_pkg
// Shared widths, constants and controller/datapath interface types for the
// trimmed-mean voltage chain.
// -----------------------------------------------------------------------------
package atmv_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int VOLT_W    = 16;
    localparam int PROD_W    = 2 * VOLT_W;
    localparam int REF_SHIFT = 12;          // full scale of the converter: 4096 codes
    localparam int DIFF_W    = VOLT_W + 2;  // signed sum - max - min of a group

    // Divider gain of the device channel: (512 + 82) / 82
    localparam int GAIN_NUM  = 512 + 82;
    localparam int GAIN_DEN  = 82;

    // Shared constant divider: dividend covers volt * GAIN_NUM
    localparam int DIV_W     = 26;

    localparam int DEF_GROUP_ATTEMPTS = 5;
    localparam int DEF_BLOCK_LENGTH   = 6;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic CFG_REF_IDX = 1'b0;
    localparam logic CFG_DEV_IDX = 1'b1;
    localparam logic [VOLT_W-1:0] REF_RESET = 16'd3300;
    localparam logic DEV_RESET = 1'b1;

    // Which constant the shared divider divides by
    typedef enum logic [1:0] {
        DIV_GROUP,
        DIV_GAIN,
        DIV_BLOCK
    } t_div_sel;

    typedef struct packed {
        logic take;        // accept one conversion attempt
        logic grp_start;   // divide trimmed group sum, clear group
        logic mul_ref;     // product <= mean * reference
        logic volt_load;   // voltage <= product / 4096
        logic mul_gain;    // product <= voltage * gain numerator
        logic gain_start;  // divide product by gain denominator
        logic blk_add;     // add scaled voltage to block
        logic blk_start;   // divide trimmed block sum, clear block
        logic held_load;   // held mean <= quotient
        logic out_load;    // load output register
    } t_dp_cmd;

    typedef struct packed {
        logic grp_last;    // next attempt closes the group
        logic blk_last;    // next value closes the block
        logic div_busy;
        logic div_done;
    } t_dp_stat;

endpackage
`default_nettype wire

FILE: sv/atmv_div.sv
`default_nettype none
// -----------------------------------------------------------------------------
// atmv_div
// Constant divider by reciprocal multiplication, unsigned operands. The
// dividend is registered at start, multiplied in the next cycle, and the
// quotient is valid from the done cycle until the next start.
// -----------------------------------------------------------------------------
module atmv_div
    import atmv_pkg::*;
#(
    parameter int GRP_DIVISOR = DEF_GROUP_ATTEMPTS - 2,
    parameter int BLK_DIVISOR = DEF_BLOCK_LENGTH - 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_div_sel         i_sel,
    input  logic [DIV_W-1:0] i_dividend,
    output logic             o_busy,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient
);

    // floor(x / d) = (x * ceil(2^k / d)) >> k for x < 2^DIV_W, k = DIV_W + clog2(d)
    localparam int REC_W  = DIV_W + 1;
    localparam int PRD_W  = DIV_W + REC_W;
    localparam int GRP_K  = DIV_W + $clog2(GRP_DIVISOR);
    localparam int GAIN_K = DIV_W + $clog2(GAIN_DEN);
    localparam int BLK_K  = DIV_W + $clog2(BLK_DIVISOR);
    localparam logic [REC_W-1:0] GRP_REC  = REC_W'(((longint'(1) << GRP_K)
        + longint'(GRP_DIVISOR) - 1) / longint'(GRP_DIVISOR));
    localparam logic [REC_W-1:0] GAIN_REC = REC_W'(((longint'(1) << GAIN_K)
        + longint'(GAIN_DEN) - 1) / longint'(GAIN_DEN));
    localparam logic [REC_W-1:0] BLK_REC  = REC_W'(((longint'(1) << BLK_K)
        + longint'(BLK_DIVISOR) - 1) / longint'(BLK_DIVISOR));

    logic             r_busy;
    logic             r_done;
    t_div_sel         r_sel;
    logic [DIV_W-1:0] r_dvd;
    logic [PRD_W-1:0] r_prod;
    logic [REC_W-1:0] recip;

    always_comb begin
        unique case (r_sel)
            DIV_GAIN: begin
                recip      = GAIN_REC;
                o_quotient = DIV_W'(r_prod >> GAIN_K);
            end
            DIV_BLOCK: begin
                recip      = BLK_REC;
                o_quotient = DIV_W'(r_prod >> BLK_K);
            end
            default: begin
                recip      = GRP_REC;
                o_quotient = DIV_W'(r_prod >> GRP_K);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_sel  <= DIV_GROUP;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
            if (i_start) begin
                r_sel <= i_sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
        end
        if (r_busy) begin
            r_prod <= PRD_W'(r_dvd) * PRD_W'(recip);
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule
`default_nettype wire

FILE: sv/atmv_dp.sv
`default_nettype none
// -----------------------------------------------------------------------------
// atmv_dp
// Datapath: group and block accumulators, shared multiplier, shared constant
// divider and the output register.
// -----------------------------------------------------------------------------
module atmv_dp
    import atmv_pkg::*;
#(
    parameter int GROUP_ATTEMPTS = DEF_GROUP_ATTEMPTS,
    parameter int BLOCK_LENGTH   = DEF_BLOCK_LENGTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_converted,
    input  logic [VOLT_W-1:0]   i_ref,
    input  logic                i_device,
    output t_dp_stat            o_stat,
    output logic [VOLT_W-1:0]   o_voltage,
    output logic                o_filtered
);

    localparam int GCNT_W = $clog2(GROUP_ATTEMPTS);
    localparam int BCNT_W = $clog2(BLOCK_LENGTH);
    localparam int BSUM_W = VOLT_W + $clog2(BLOCK_LENGTH);
    localparam logic [VOLT_W-1:0] GAIN_FACTOR = VOLT_W'(GAIN_NUM);

    // Group state
    logic [GCNT_W-1:0]   r_gcnt;
    logic [VOLT_W-1:0]   r_gsum;
    logic [SAMPLE_W-1:0] r_gmax;
    logic [VOLT_W-1:0]   r_gmin;
    // Block state
    logic [BCNT_W-1:0]   r_bcnt;
    logic [BSUM_W-1:0]   r_bsum;
    logic [VOLT_W-1:0]   r_bmax;
    logic [VOLT_W-1:0]   r_bmin;
    logic [VOLT_W-1:0]   r_held;
    // Working registers
    logic                r_gneg;
    logic [PROD_W-1:0]   r_prod;
    logic [VOLT_W-1:0]   r_volt;
    logic [VOLT_W-1:0]   r_out_volt;
    logic                r_out_filt;

    logic [DIFF_W-1:0]   g_diff;
    logic                g_neg;
    logic [DIFF_W-1:0]   g_mag;
    logic [BSUM_W-1:0]   b_trim;
    logic                div_start;
    logic [DIV_W-1:0]    div_dividend;
    t_div_sel            div_sel;
    logic                div_busy;
    logic                div_done;
    logic [DIV_W-1:0]    div_quo;
    logic [VOLT_W-1:0]   quo16;
    logic [VOLT_W-1:0]   mean;
    logic [VOLT_W-1:0]   mul_a;
    logic [VOLT_W-1:0]   mul_b;
    logic                use_held;

    always_comb begin
        g_diff = DIFF_W'(r_gsum) - DIFF_W'(r_gmax) - DIFF_W'(r_gmin);
        g_neg  = g_diff[DIFF_W-1];
        g_mag  = g_neg ? (~g_diff + 1'b1) : g_diff;
        // Block sum always contains both extremes, so this stays non-negative
        b_trim = r_bsum - BSUM_W'(r_bmax) - BSUM_W'(r_bmin);
    end

    always_comb begin
        div_start    = i_cmd.grp_start | i_cmd.gain_start | i_cmd.blk_start;
        div_dividend = DIV_W'(g_mag);
        div_sel      = DIV_GROUP;
        if (i_cmd.gain_start) begin
            div_dividend = r_prod[DIV_W-1:0];
            div_sel      = DIV_GAIN;
        end else if (i_cmd.blk_start) begin
            div_dividend = DIV_W'(b_trim);
            div_sel      = DIV_BLOCK;
        end
    end

    atmv_div #(
        .GRP_DIVISOR (GROUP_ATTEMPTS - 2),
        .BLK_DIVISOR (BLOCK_LENGTH - 2)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_sel      (div_sel),
        .i_dividend (div_dividend),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        quo16 = div_quo[VOLT_W-1:0];
        // Truncation toward zero: negate the magnitude quotient, keep 16 bits
        mean  = r_gneg ? (~quo16 + 1'b1) : quo16;
        mul_a = i_cmd.mul_ref ? mean  : r_volt;
        mul_b = i_cmd.mul_ref ? i_ref : GAIN_FACTOR;
        use_held = i_device && (r_held != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gcnt <= '0;
            r_gsum <= '0;
            r_gmax <= '0;
            r_gmin <= '1;
            r_bcnt <= '0;
            r_bsum <= '0;
            r_bmax <= '0;
            r_bmin <= '1;
            r_held <= '0;
        end else begin
            if (i_cmd.take) begin
                if (i_converted) begin
                    r_gsum <= r_gsum + VOLT_W'(i_sample);
                    if (i_sample > r_gmax) begin
                        r_gmax <= i_sample;
                    end
                    if (VOLT_W'(i_sample) < r_gmin) begin
                        r_gmin <= VOLT_W'(i_sample);
                    end
                end
                r_gcnt <= o_stat.grp_last ? '0 : r_gcnt + 1'b1;
            end
            if (i_cmd.grp_start) begin
                r_gsum <= '0;
                r_gmax <= '0;
                r_gmin <= '1;
            end
            if (i_cmd.blk_add) begin
                r_bsum <= r_bsum + BSUM_W'(quo16);
                if (quo16 > r_bmax) begin
                    r_bmax <= quo16;
                end
                if (quo16 < r_bmin) begin
                    r_bmin <= quo16;
                end
                r_bcnt <= o_stat.blk_last ? '0 : r_bcnt + 1'b1;
            end
            if (i_cmd.blk_start) begin
                r_bsum <= '0;
                r_bmax <= '0;
                r_bmin <= '1;
            end
            if (i_cmd.held_load) begin
                r_held <= quo16;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.grp_start) begin
            r_gneg <= g_neg;
        end
        if (i_cmd.mul_ref || i_cmd.mul_gain) begin
            r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (i_cmd.volt_load) begin
            r_volt <= r_prod[REF_SHIFT +: VOLT_W];
        end else if (i_cmd.blk_add) begin
            r_volt <= quo16;
        end
        if (i_cmd.out_load) begin
            r_out_volt <= use_held ? r_held : r_volt;
            r_out_filt <= use_held;
        end
    end

    assign o_stat.grp_last = (r_gcnt == GCNT_W'(GROUP_ATTEMPTS - 1));
    assign o_stat.blk_last = (r_bcnt == BCNT_W'(BLOCK_LENGTH - 1));
    assign o_stat.div_busy = div_busy;
    assign o_stat.div_done = div_done;
    assign o_voltage       = r_out_volt;
    assign o_filtered      = r_out_filt;

endmodule
`default_nettype wire

FILE: sv/atmv_ctrl.sv
`default_nettype none
// -----------------------------------------------------------------------------
// atmv_ctrl
// Sequencer: takes attempts, walks the group-end computation and hands the
// result beat to the output register.
// -----------------------------------------------------------------------------
module atmv_ctrl
    import atmv_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_ready,
    input  logic     i_device,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output logic     o_out_valid,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_GSTART,
        S_GWAIT,
        S_MREF,
        S_VOLT,
        S_GAIN,
        S_DSTART,
        S_DWAIT,
        S_BLK,
        S_BSTART,
        S_BWAIT,
        S_HOLD,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd            = '0;
        o_cmd.take       = (r_state == S_IDLE) && i_in_valid;
        o_cmd.grp_start  = (r_state == S_GSTART);
        o_cmd.mul_ref    = (r_state == S_MREF);
        o_cmd.volt_load  = (r_state == S_VOLT);
        o_cmd.mul_gain   = (r_state == S_GAIN);
        o_cmd.gain_start = (r_state == S_DSTART);
        o_cmd.blk_add    = (r_state == S_BLK);
        o_cmd.blk_start  = (r_state == S_BSTART);
        o_cmd.held_load  = (r_state == S_HOLD);
        o_cmd.out_load   = (r_state == S_OUT) && out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_stat.grp_last) begin
                    n_state = S_GSTART;
                end
            end
            S_GSTART: n_state = S_GWAIT;
            S_GWAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_MREF;
                end
            end
            S_MREF: n_state = S_VOLT;
            S_VOLT: n_state = i_device ? S_GAIN : S_OUT;
            S_GAIN: n_state = S_DSTART;
            S_DSTART: n_state = S_DWAIT;
            S_DWAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_BLK;
                end
            end
            S_BLK: n_state = i_stat.blk_last ? S_BSTART : S_OUT;
            S_BSTART: n_state = S_BWAIT;
            S_BWAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

FILE: sv/atmv_regs.sv
`default_nettype none
// -----------------------------------------------------------------------------
// atmv_regs
// Configuration registers behind the APB port: reference millivolts and
// channel select.
// -----------------------------------------------------------------------------
module atmv_regs
    import atmv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [VOLT_W-1:0]  o_ref,
    output logic               o_device
);

    logic [VOLT_W-1:0] r_ref;
    logic              r_dev;
    logic              wr_en;
    logic              reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= REF_RESET;
            r_dev <= DEV_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                CFG_REF_IDX: r_ref <= pwdata[VOLT_W-1:0];
                CFG_DEV_IDX: r_dev <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            CFG_REF_IDX: prdata = PDATA_W'(r_ref);
            CFG_DEV_IDX: prdata = PDATA_W'(r_dev);
            default:     prdata = '0;
        endcase
    end

    assign o_ref    = r_ref;
    assign o_device = r_dev;

endmodule
`default_nettype wire

FILE: sv/adc_trimmed_mean_voltage_chain.sv
`default_nettype none
// -----------------------------------------------------------------------------
// adc_trimmed_mean_voltage_chain
// Trimmed-mean voltage measurement chain with optional block filter.
// -----------------------------------------------------------------------------
// Each input beat is one conversion attempt (sample, converted flag). Every
// GROUP_ATTEMPTS attempts one output beat is produced: the good samples minus
// their highest and lowest, divided by GROUP_ATTEMPTS-2, scaled by
// ref_millivolts/4096. In device mode the value is scaled by 594/82 and fed to
// a block filter that holds the trimmed mean of every BLOCK_LENGTH values;
// tuser marks a held mean. An attempt that does not close a group is taken
// without a stall. A group-closing attempt keeps the input stalled while one
// reciprocal-multiply constant divider and one 16x16 multiplier work through
// the group division and reference multiply, in device mode also the gain
// multiply and division, and the block division when a block also closes,
// plus any wait for the previous output beat to be taken. The output register
// lets the next attempts in while a result beat waits.
// -----------------------------------------------------------------------------
module adc_trimmed_mean_voltage_chain
    import atmv_pkg::*;
#(
    parameter int GROUP_ATTEMPTS = DEF_GROUP_ATTEMPTS,
    parameter int BLOCK_LENGTH   = DEF_BLOCK_LENGTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [15:0]        s_axis_tdata,  // [11:0] sample, [15:12] zero
    input  logic               s_axis_tuser,  // [0] converted
    // Output stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [15:0]        m_axis_tdata,  // [15:0] voltage
    output logic               m_axis_tuser,  // [0] filtered
    // Configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [VOLT_W-1:0] cfg_ref;
    logic              cfg_device;
    t_dp_cmd           dp_cmd;
    t_dp_stat          dp_stat;

    atmv_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_ref    (cfg_ref),
        .o_device (cfg_device)
    );

    atmv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_device    (cfg_device),
        .i_stat      (dp_stat),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (dp_cmd)
    );

    atmv_dp #(
        .GROUP_ATTEMPTS (GROUP_ATTEMPTS),
        .BLOCK_LENGTH   (BLOCK_LENGTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_sample    (s_axis_tdata[SAMPLE_W-1:0]),
        .i_converted (s_axis_tuser),
        .i_ref       (cfg_ref),
        .i_device    (cfg_device),
        .o_stat      (dp_stat),
        .o_voltage   (m_axis_tdata),
        .o_filtered  (m_axis_tuser)
    );

`ifndef SYNTHESIS
    a_no_take_while_dividing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        dp_stat.div_busy |-> !s_axis_tready
    ) else $error("input ready while divider busy");

    a_div_done_pulse: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        dp_stat.div_done |=> !dp_stat.div_done
    ) else $error("divider done held longer than one cycle");

    a_group_end_stalls: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && dp_stat.grp_last) |=> !s_axis_tready
    ) else $error("group-closing beat did not stall input");
`endif

endmodule
`default_nettype wire

FILE: dv/tb_adc_trimmed_mean_voltage_chain.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_adc_trimmed_mean_voltage_chain
// Self-checking bench for the trimmed-mean voltage chain. Conversion attempts
// go in on the input stream. A scoreboard tracks group and block state and
// predicts each voltage beat. Random gaps and bursts run on both streams.
// The reference and the channel mode are reprogrammed between phases.
// -----------------------------------------------------------------------------
module tb_adc_trimmed_mean_voltage_chain
    import atmv_pkg::*;
;

    localparam int     CLK_PERIOD     = 10;
    localparam int     RESET_CYCLES   = 7;
    localparam int     MAX_GAP        = 16;
    localparam int     SETTLE_CYCLES  = 200;
    localparam int     DRAIN_LIMIT    = 50000;
    localparam longint TIMEOUT_NS     = 5_000_000;
    localparam int     TRIM_GROUP     = DEF_GROUP_ATTEMPTS - 2;
    localparam int     TRIM_BLOCK     = DEF_BLOCK_LENGTH - 2;
    localparam int     ADC_FULL_SCALE = 1 << REF_SHIFT;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MID = 12'h800;
    localparam logic [VOLT_W-1:0]   REF_MAX    = '1;
    localparam logic [PADDR_W-1:0]  REF_ADDR   = {CFG_REF_IDX, 2'b00};
    localparam logic [PADDR_W-1:0]  DEV_ADDR   = {CFG_DEV_IDX, 2'b00};
    localparam logic DEVICE_MODE = 1'b1;
    localparam logic MOTOR_MODE  = 1'b0;
    localparam logic CONV_OK     = 1'b1;
    localparam logic CONV_FAIL   = 1'b0;

    typedef struct packed {
        logic [VOLT_W-1:0] voltage;
        logic              filtered;
    } t_reading;

    class trimmed_mean_scoreboard;
        logic [VOLT_W-1:0] ref_mv;
        logic              device_path;
        int unsigned       attempts;
        int unsigned       grp_sum, grp_max, grp_min;
        int unsigned       blk_count, blk_sum, blk_max, blk_min;
        int unsigned       held_mean;
        t_reading          expected_readings[$];
        int                errors;

        function new();
            ref_mv      = REF_RESET;
            device_path = DEV_RESET;
            held_mean   = 0;
            errors      = 0;
            clear_group();
            clear_block();
        endfunction

        function void clear_group();
            attempts = 0;
            grp_sum  = 0;
            grp_max  = 0;
            grp_min  = 16'hFFFF;
        endfunction

        function void clear_block();
            blk_count = 0;
            blk_sum   = 0;
            blk_max   = 0;
            blk_min   = 16'hFFFF;
        endfunction

        task report(input string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        // Fold one accepted attempt in; queue a reading when it closes a group.
        function void note_attempt(input logic [SAMPLE_W-1:0] sample, input logic ok);
            int          diff;
            int unsigned mean;
            int unsigned volt;
            t_reading    r;
            if (ok) begin
                grp_sum = (grp_sum + sample) & 16'hFFFF;
                if (sample > grp_max) grp_max = sample;
                if (sample < grp_min) grp_min = sample;
            end
            attempts++;
            if (attempts < DEF_GROUP_ATTEMPTS) return;

            // signed trim: can go negative only when fewer than two samples were good
            diff = int'(grp_sum) - int'(grp_max) - int'(grp_min);
            diff = diff / TRIM_GROUP;
            mean = diff & 32'hFFFF;
            volt = ((longint'(mean) * ref_mv) / ADC_FULL_SCALE) & 16'hFFFF;
            clear_group();

            r.filtered = 1'b0;
            if (device_path) begin
                volt = ((volt * GAIN_NUM) / GAIN_DEN) & 16'hFFFF;
                blk_sum += volt;
                if (volt > blk_max) blk_max = volt;
                if (volt < blk_min) blk_min = volt;
                blk_count++;
                if (blk_count >= DEF_BLOCK_LENGTH) begin
                    held_mean = ((blk_sum - blk_max - blk_min) / TRIM_BLOCK) & 16'hFFFF;
                    clear_block();
                end
                // pass the current value through while nothing is held
                if (held_mean != 0) begin
                    volt       = held_mean;
                    r.filtered = 1'b1;
                end
            end
            r.voltage = VOLT_W'(volt);
            expected_readings.push_back(r);
        endfunction

        task check_reading(input logic [VOLT_W-1:0] voltage, input logic filtered);
            t_reading want;
            if (expected_readings.size() == 0) begin
                report($sformatf("unexpected beat voltage=%0d filtered=%0b",
                                 voltage, filtered));
                return;
            end
            want = expected_readings.pop_front();
            if (voltage !== want.voltage)
                report($sformatf("voltage got %0d want %0d", voltage, want.voltage));
            if (filtered !== want.filtered)
                report($sformatf("filtered got %0b want %0b", filtered, want.filtered));
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata;   // [11:0] sample, [15:12] zero
    logic               s_axis_tuser;   // [0] converted
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [15:0]        m_axis_tdata;   // [15:0] voltage
    logic               m_axis_tuser;   // [0] filtered
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    trimmed_mean_scoreboard sb;
    bit send_burst;
    bit recv_burst;

    adc_trimmed_mean_voltage_chain dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("[adc_trimmed_mean_voltage_chain] ERROR");
        $finish;
    end

    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == REF_ADDR)
            sb.ref_mv = data[VOLT_W-1:0];
        else if (addr == DEV_ADDR)
            sb.device_path = data[0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_chain(input logic [VOLT_W-1:0] ref_mv, input logic mode);
        reg_write(REF_ADDR, PDATA_W'(ref_mv));
        reg_write(DEV_ADDR, PDATA_W'(mode));
    endtask

    // Present one attempt after a random gap and hold it until the beat is taken.
    task automatic send_attempt(input logic [SAMPLE_W-1:0] sample, input logic ok);
        int gap;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : int'($urandom_range(0, MAX_GAP));
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(16 - SAMPLE_W){1'b0}}, sample};
        s_axis_tuser  <= ok;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_attempt(sample, ok);
    endtask

    task automatic run_random(input int count);
        int                  fail_pct;
        logic [SAMPLE_W-1:0] sample;
        fail_pct = 5;
        for (int k = 0; k < count; k++) begin
            // pick a failure profile at each group start
            if (sb.attempts == 0) begin
                case ($urandom_range(0, 9))
                    0:       fail_pct = 100;
                    1, 2:    fail_pct = 70;
                    default: fail_pct = 5;
                endcase
            end
            case ($urandom_range(0, 9))
                0:       sample = '0;
                1:       sample = SAMPLE_MAX;
                2:       sample = SAMPLE_W'($urandom_range(0, 15));
                default: sample = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
            endcase
            send_attempt(sample, $urandom_range(0, 99) >= fail_pct);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Wait for every queued reading, then let the block settle.
    task automatic wait_idle();
        int cycles;
        cycles = 0;
        while (sb.expected_readings.size() != 0 && cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Output side: random stalls, with occasional bursts of always-ready.
    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 7) == 0) recv_burst = !recv_burst;
            gap = recv_burst ? 0 : int'($urandom_range(0, MAX_GAP));
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_reading(m_axis_tdata, m_axis_tuser);
        end
    end

    initial begin
        sb = new();
        send_burst = 1'b0;
        recv_burst = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full-scale group
        repeat (5) send_attempt(SAMPLE_MAX, CONV_OK);
        // every attempt times out: empty group wraps negative
        repeat (5) send_attempt(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)), CONV_FAIL);
        // one good zero sample
        send_attempt('0, CONV_OK);
        repeat (4) send_attempt(SAMPLE_MAX, CONV_FAIL);
        // one good full-scale sample counts as both max and min
        send_attempt(SAMPLE_MAX, CONV_OK);
        repeat (4) send_attempt('0, CONV_FAIL);
        // mixed extremes
        send_attempt('0, CONV_OK);
        send_attempt(SAMPLE_MAX, CONV_OK);
        send_attempt(SAMPLE_MID, CONV_OK);
        send_attempt(12'd1, CONV_OK);
        send_attempt(SAMPLE_MAX - 1'b1, CONV_OK);
        s_axis_tvalid <= 1'b0;
        wait_idle();

        // zero reference drains the block filter back to pass-through
        program_chain('0, DEVICE_MODE);
        run_random(70);
        wait_idle();
        program_chain(REF_MAX, DEVICE_MODE);
        run_random(200);
        wait_idle();
        // motor mode must leave the block filter untouched
        program_chain(REF_MAX, MOTOR_MODE);
        run_random(150);
        wait_idle();
        program_chain(REF_RESET, DEVICE_MODE);
        run_random(200);
        wait_idle();
        program_chain(16'd1, DEVICE_MODE);
        run_random(100);
        wait_idle();
        program_chain(16'd4096, MOTOR_MODE);
        run_random(100);
        wait_idle();
        repeat (3) begin
            program_chain(VOLT_W'($urandom_range(0, REF_MAX)), 1'($urandom_range(0, 1)));
            run_random(150);
            wait_idle();
        end

        if (sb.expected_readings.size() != 0)
            sb.report($sformatf("%0d readings never arrived", sb.expected_readings.size()));
        if (sb.errors == 0)
            $display("[adc_trimmed_mean_voltage_chain] OK");
        else
            $display("[adc_trimmed_mean_voltage_chain] ERROR");
        $finish;
    end

endmodule
